>>> sv/etg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etg_pkg: shared types and constants for the enveloped tone generator
// Register map, configuration bundle, sequencer states and the sine ROM.
// ----------------------------------------------------------------------------
package etg_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int ATTACK_SAMPLES   = 220;

    localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_ADDR_W  = SINE_ADDR_W + 1;

    localparam int Q16_ONE     = 65536;
    localparam int HARM_GAIN   = 19661;
    localparam int PCM_SCALE   = 32767;
    localparam longint HALF_PI_Q30 = 1686629713;

    localparam int ATT_DIV   = 2 * ATTACK_SAMPLES + 1;
    localparam int ATT_QSTEP = 131072 / ATT_DIV;
    localparam int ATT_RSTEP = 131072 % ATT_DIV;
    localparam int ATT_R_W   = $clog2(ATT_DIV) + 1;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_WAVE_SELECT = 3'd0,
        REG_PHASE_STEP  = 3'd1,
        REG_TONE_LENGTH = 3'd2,
        REG_VOLUME_GAIN = 3'd3,
        REG_DECAY_START = 3'd4,
        REG_DECAY_STEP  = 3'd5
    } etg_reg_t;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SINE     = 2'd2
    } etg_wave_t;

    typedef struct packed {
        logic [1:0]  wave_select;
        logic [31:0] phase_step;
        logic [19:0] tone_length;
        logic [15:0] volume_gain;
        logic [25:0] decay_start;
        logic [25:0] decay_step;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_HARM,
        S_WAVE,
        S_ATT,
        S_DEC,
        S_VOL,
        S_SCL,
        S_DONE
    } etg_state_t;

    typedef logic [16:0] sine_tab_t [SINE_TABLE_DEPTH+1];

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] v;
        longint      sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x   = (64'(HALF_PI_Q30) * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            t   = x;
            sum = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (64'(sum) + 64'd8192) >> 14;
            if (v > 64'(Q16_ONE)) begin
                v = 64'(Q16_ONE);
            end
            tab[k] = v[16:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

>>> sv/etg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etg_regs: configuration register file
// APB-style write and read access to the six tone settings.
// ----------------------------------------------------------------------------
module etg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [etg_pkg::PADDR_W-1:0] paddr,
    input  wire logic [etg_pkg::PDATA_W-1:0] pwdata,
    output logic      [etg_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output etg_pkg::cfg_t                    cfg
);
    import etg_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    etg_reg_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = etg_reg_t'(paddr[4:2]);
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{wave_select: 2'd0, phase_step: 32'd0, tone_length: 20'd1,
                         volume_gain: 16'd0, decay_start: 26'd0, decay_step: 26'd0};
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_WAVE_SELECT: cfg_reg.wave_select <= pwdata[1:0];
                REG_PHASE_STEP:  cfg_reg.phase_step  <= pwdata;
                REG_TONE_LENGTH: cfg_reg.tone_length <= pwdata[19:0];
                REG_VOLUME_GAIN: cfg_reg.volume_gain <= pwdata[15:0];
                REG_DECAY_START: cfg_reg.decay_start <= pwdata[25:0];
                REG_DECAY_STEP:  cfg_reg.decay_step  <= pwdata[25:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_WAVE_SELECT: prdata = {30'd0, cfg_reg.wave_select};
            REG_PHASE_STEP:  prdata = cfg_reg.phase_step;
            REG_TONE_LENGTH: prdata = {12'd0, cfg_reg.tone_length};
            REG_VOLUME_GAIN: prdata = {16'd0, cfg_reg.volume_gain};
            REG_DECAY_START: prdata = {6'd0, cfg_reg.decay_start};
            REG_DECAY_STEP:  prdata = {6'd0, cfg_reg.decay_step};
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/enveloped_tone_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enveloped_tone_generator_core: sample-tick tone synthesizer with envelope
// Each accepted tick yields one signed 16-bit sample. A tone sample steps
// through PREP, HARM, WAVE, ATT, DEC, VOL, SCL and DONE; a silent tick
// goes from PREP to DONE. No new tick is taken before IDLE. The sequencer
// uses a single 19x26 multiplier five times per sample (harmonic gain,
// attack, decay, volume, output scale). The result sits in an output
// register, so the next tick can be accepted while it waits for transfer.
// ----------------------------------------------------------------------------
module enveloped_tone_generator_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_restart,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [15:0]               m_pcm_sample,
    output logic                             m_tone_active,
    output logic                             m_last_sample,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [etg_pkg::PADDR_W-1:0] paddr,
    input  wire logic [etg_pkg::PDATA_W-1:0] pwdata,
    output logic      [etg_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import etg_pkg::*;

    localparam logic signed [18:0] W_ONE = 19'sd65536;

    cfg_t       cfg;
    etg_state_t state_reg, state_next;

    logic [31:0]         phase_acc_reg;
    logic [19:0]         sample_index_reg;
    logic [16:0]         att_q_reg;
    logic [ATT_R_W-1:0]  att_r_reg;
    logic [25:0]         decay_level_reg;
    logic                playing_reg;
    logic                active_reg;
    logic                last_reg;
    logic [16:0]         rom_q_reg;
    logic                sin_neg_reg;
    logic                neg_reg;
    logic [16:0]         mag_reg;
    logic [44:0]         prod_reg;

    logic                m_valid_reg;
    logic signed [15:0]  m_pcm_sample_reg;
    logic                m_tone_active_reg;
    logic                m_last_sample_reg;

    logic                s_fire;
    logic                out_free;
    logic                advance;
    logic [31:0]         sel_phase;
    logic [ROM_ADDR_W-1:0] fine_idx;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic [19:0]         len_eff;
    logic                last_next;
    logic [16:0]         att_val;
    logic [18:0]         mul_a;
    logic [25:0]         mul_b;
    logic [18:0]         scl_in;
    logic [16:0]         tri_d;
    logic signed [18:0]  harm_s;
    logic signed [18:0]  w_val;
    logic [18:0]         w_abs;
    logic [15:0]         out_mag;
    logic [ATT_R_W-1:0]  att_r_sum;

    etg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign advance       = (state_reg == S_DONE) && out_free && active_reg;
    assign m_valid       = m_valid_reg;
    assign m_pcm_sample  = m_pcm_sample_reg;
    assign m_tone_active = m_tone_active_reg;
    assign m_last_sample = m_last_sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_fire) state_next = S_PREP;
            S_PREP:  state_next = playing_reg ? S_HARM : S_DONE;
            S_HARM:  state_next = S_WAVE;
            S_WAVE:  state_next = S_ATT;
            S_ATT:   state_next = S_DEC;
            S_DEC:   state_next = S_VOL;
            S_VOL:   state_next = S_SCL;
            S_SCL:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        sel_phase = (cfg.wave_select == WAVE_SQUARE) ? {phase_acc_reg[30:0], 1'b0}
                                                     : phase_acc_reg;
        fine_idx  = {1'b0, sel_phase[29 -: SINE_ADDR_W]};
        rom_addr  = sel_phase[30] ? ROM_ADDR_W'(SINE_TABLE_DEPTH) - fine_idx : fine_idx;
        len_eff   = (cfg.tone_length == 20'd0) ? 20'd1 : cfg.tone_length;
        last_next = ({1'b0, sample_index_reg} + 21'd1) >= {1'b0, len_eff};
        att_val   = (att_q_reg >= 17'(Q16_ONE)) ? 17'(Q16_ONE) : att_q_reg;
        att_r_sum = att_r_reg + ATT_R_W'(ATT_RSTEP);
        scl_in    = (prod_reg[34:16] > 19'(Q16_ONE)) ? 19'(Q16_ONE) : prod_reg[34:16];
        out_mag   = prod_reg[31:16];
    end

    always_comb begin
        tri_d  = phase_acc_reg[31] ? {1'b0, phase_acc_reg[30:15]}
                                   : 17'(Q16_ONE) - {1'b0, phase_acc_reg[30:15]};
        harm_s = $signed({2'b00, prod_reg[32:16]});
        unique case (cfg.wave_select)
            WAVE_SQUARE: begin
                w_val = (phase_acc_reg[31] ? -W_ONE : W_ONE)
                      + (sin_neg_reg ? -harm_s : harm_s);
            end
            WAVE_TRIANGLE: begin
                w_val = $signed({1'b0, tri_d, 1'b0}) - W_ONE;
            end
            default: begin
                w_val = sin_neg_reg ? -$signed({2'b00, rom_q_reg})
                                    : $signed({2'b00, rom_q_reg});
            end
        endcase
        w_abs = w_val[18] ? 19'(-w_val) : 19'(w_val);
    end

    always_comb begin
        unique case (state_reg)
            S_HARM: begin
                mul_a = {2'b00, rom_q_reg};
                mul_b = 26'(HARM_GAIN);
            end
            S_ATT: begin
                mul_a = {2'b00, mag_reg};
                mul_b = {9'd0, att_val};
            end
            S_DEC: begin
                mul_a = prod_reg[34:16];
                mul_b = decay_level_reg;
            end
            S_VOL: begin
                mul_a = prod_reg[42:24];
                mul_b = {10'd0, cfg.volume_gain};
            end
            S_SCL: begin
                mul_a = scl_in;
                mul_b = 26'(PCM_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg != S_DONE) begin
            prod_reg <= 45'(mul_a) * 45'(mul_b);
        end
        if (state_reg == S_PREP) begin
            rom_q_reg   <= SINE_TAB[rom_addr];
            sin_neg_reg <= sel_phase[31];
            last_reg    <= last_next;
        end
        if (state_reg == S_WAVE) begin
            neg_reg <= w_val[18];
            mag_reg <= w_abs[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            att_q_reg        <= '0;
            att_r_reg        <= '0;
            decay_level_reg  <= '0;
            playing_reg      <= 1'b0;
            active_reg       <= 1'b0;
        end else begin
            if (s_fire && s_restart) begin
                phase_acc_reg    <= '0;
                sample_index_reg <= '0;
                att_q_reg        <= '0;
                att_r_reg        <= '0;
                decay_level_reg  <= cfg.decay_start;
                playing_reg      <= 1'b1;
            end else if (advance) begin
                phase_acc_reg    <= phase_acc_reg + cfg.phase_step;
                sample_index_reg <= sample_index_reg + 20'd1;
                decay_level_reg  <= (decay_level_reg > cfg.decay_step)
                                  ? decay_level_reg - cfg.decay_step : 26'd0;
                if (att_q_reg < 17'(Q16_ONE)) begin
                    if (att_r_sum >= ATT_R_W'(ATT_DIV)) begin
                        att_r_reg <= att_r_sum - ATT_R_W'(ATT_DIV);
                        att_q_reg <= att_q_reg + 17'(ATT_QSTEP) + 17'd1;
                    end else begin
                        att_r_reg <= att_r_sum;
                        att_q_reg <= att_q_reg + 17'(ATT_QSTEP);
                    end
                end
                if (last_reg) begin
                    playing_reg <= 1'b0;
                end
            end
            if (state_reg == S_PREP) begin
                active_reg <= playing_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            if (active_reg) begin
                m_pcm_sample_reg  <= neg_reg ? -$signed(out_mag) : $signed(out_mag);
                m_tone_active_reg <= 1'b1;
                m_last_sample_reg <= last_reg;
            end else begin
                m_pcm_sample_reg  <= '0;
                m_tone_active_reg <= 1'b0;
                m_last_sample_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/etg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etg_checker: port-level checks for the enveloped tone generator
// Watches the sample channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module etg_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_pcm_sample,
    input wire logic               m_tone_active,
    input wire logic               m_last_sample
);

    a_silence_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tone_active |-> (m_pcm_sample == 16'sd0) && !m_last_sample)
        else $error("silent transfer carries a nonzero sample or last flag");

    a_pcm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pcm_sample != -16'sd32768))
        else $error("sample outside the clamped range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pcm_sample)
                                && $stable(m_tone_active) && $stable(m_last_sample))
        else $error("stalled result changed or dropped");

endmodule

bind enveloped_tone_generator_core etg_checker u_etg_checker (.*);
`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sample-accurate check of the enveloped tone generator core
// Sends sample ticks in random bursts, programs the registers over APB while
// the core is idle, predicts samples with a fixed-point model of the
// synthesizer or a directed row, and compares each transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
    import etg_pkg::*;

    localparam int     ROM_DEPTH    = 256;
    localparam int     ATTACK_DIV   = 2 * 220 + 1;
    localparam longint ONE_Q16      = 65536;
    localparam longint HARMONIC_Q16 = 19661;
    localparam longint FULL_SCALE   = 32767;
    localparam longint HALF_PI_Q30V = 1686629713;
    localparam int     N_DIRECTED   = 28;
    localparam int     RANDOM_TICKS = 1050;
    localparam int     MAX_PRINTED  = 50;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic               active;
        logic               last;
    } tone_sample_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        bit           restart;
        etg_reg_t     reg_sel;
        logic [31:0]  value;
        bit           fixed;
        tone_sample_t sample;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_restart;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [15:0]   m_pcm_sample;
    logic                 m_tone_active;
    logic                 m_last_sample;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    cfg_t         tone_cfg;
    logic [31:0]  phase_acc_q;
    logic [19:0]  sample_idx_q;
    logic [25:0]  decay_q;
    bit           playing_q;
    longint       quarter_sine [ROM_DEPTH+1];
    tone_sample_t pending_samples [$];
    int           mismatch_count = 0;
    int           ticks_sent = 0;
    int           burst_left = 0;
    int           rx_left = 0;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b1, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b1, 1'b1}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_TONE_LENGTH, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b1, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b1, 1'b1}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_VOLUME_GAIN, 32'h0000_FFFF,    1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_DECAY_START, 32'h03FF_FFFF,    1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_DECAY_STEP,  32'h0010_0000,    1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_PHASE_STEP,  32'h8000_0000,    1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_TONE_LENGTH, 32'd6,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b1, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b1, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_WAVE_SELECT, 32'(WAVE_TRIANGLE), 1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        // unassigned waveform code, plays as sine
        '{ROW_WRITE, 1'b0, REG_WAVE_SELECT, 32'd3,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b1, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b1, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_DECAY_STEP,  32'h03FF_FFFF,    1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_WAVE_SELECT, 32'(WAVE_SINE),   1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_WRITE, 1'b0, REG_PHASE_STEP,  32'hFFFF_FFFF,    1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b0, '{16'sd0, 1'b0, 1'b0}},
        '{ROW_TICK,  1'b0, REG_WAVE_SELECT, 32'd0,            1'b1, '{16'sd0, 1'b0, 1'b0}}
    };

    enveloped_tone_generator_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pcm_sample  (m_pcm_sample),
        .m_tone_active (m_tone_active),
        .m_last_sample (m_last_sample),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic void build_quarter_sine();
        bit [63:0] x;
        bit [63:0] t;
        bit [63:0] v;
        longint    acc;
        for (int k = 0; k <= ROM_DEPTH; k++) begin
            x   = (64'(HALF_PI_Q30V) * 64'(k)) / 64'(ROM_DEPTH);
            t   = x;
            acc = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                acc = ((n % 2) == 1) ? acc - longint'(t) : acc + longint'(t);
            end
            if (acc < 0) acc = 0;
            v = (64'(acc) + 64'd8192) >> 14;
            quarter_sine[k] = (v > 64'(ONE_Q16)) ? ONE_Q16 : longint'(v);
        end
    endfunction

    function automatic longint sine_q16(logic [31:0] ph);
        int     idx;
        longint v;
        idx = int'((64'(ph[29:0]) * 64'(ROM_DEPTH)) >> 30);
        if (ph[30]) idx = ROM_DEPTH - idx;
        v = quarter_sine[idx];
        return ph[31] ? -v : v;
    endfunction

    function automatic longint wave_q16(logic [31:0] ph);
        longint sq;
        longint h;
        longint m;
        longint d;
        case (tone_cfg.wave_select)
            WAVE_SQUARE: begin
                sq = ph[31] ? -ONE_Q16 : ONE_Q16;
                h  = sine_q16({ph[30:0], 1'b0});
                m  = ((h < 0 ? -h : h) * HARMONIC_Q16) >> 16;
                return (h < 0) ? sq - m : sq + m;
            end
            WAVE_TRIANGLE: begin
                d = longint'(ph >> 15) - ONE_Q16;
                if (d < 0) d = -d;
                return 2 * d - ONE_Q16;
            end
            default: return sine_q16(ph);
        endcase
    endfunction

    function automatic tone_sample_t synth_next_sample(bit restart);
        tone_sample_t res;
        logic [31:0]  len;
        bit           is_last;
        longint       att;
        longint       w;
        bit           neg;
        bit [63:0]    mag;
        res = '0;
        if (restart) begin
            phase_acc_q  = '0;
            sample_idx_q = '0;
            decay_q      = tone_cfg.decay_start;
            playing_q    = 1'b1;
        end
        if (!playing_q) return res;
        len     = (tone_cfg.tone_length == 0) ? 32'd1 : 32'(tone_cfg.tone_length);
        is_last = (32'(sample_idx_q) + 32'd1) >= len;
        att     = (longint'(sample_idx_q) * 131072) / ATTACK_DIV;
        if (att > ONE_Q16) att = ONE_Q16;
        w   = wave_q16(phase_acc_q);
        neg = (w < 0);
        mag = neg ? 64'(-w) : 64'(w);
        mag = (mag * 64'(att)) >> 16;
        mag = (mag * 64'(decay_q)) >> 24;
        mag = (mag * 64'(tone_cfg.volume_gain)) >> 16;
        if (mag > 64'(ONE_Q16)) mag = 64'(ONE_Q16);
        mag = (mag * 64'(FULL_SCALE)) >> 16;
        res.pcm    = neg ? -16'(mag) : 16'(mag);
        res.active = 1'b1;
        res.last   = is_last;
        phase_acc_q  = phase_acc_q + tone_cfg.phase_step;
        sample_idx_q = sample_idx_q + 20'd1;
        decay_q      = (decay_q > tone_cfg.decay_step) ? decay_q - tone_cfg.decay_step : '0;
        if (is_last) playing_q = 1'b0;
        return res;
    endfunction

    function automatic logic [31:0] pick_reg_value(etg_reg_t sel);
        int pick;
        pick = $urandom_range(0, 7);
        case (sel)
            REG_WAVE_SELECT: return $urandom_range(0, 3);
            REG_PHASE_STEP: begin
                if (pick == 0) return 32'h0;
                if (pick == 1) return 32'hFFFF_FFFF;
                if (pick == 2) return 32'h8000_0000;
                if (pick < 5) return $urandom_range(0, 32'h0400_0000);
                return $urandom;
            end
            REG_TONE_LENGTH: begin
                if (pick == 0) return 32'd0;
                if (pick == 1) return 32'd1;
                if (pick == 2 && $urandom_range(0, 3) == 0) return 32'h000F_FFFF;
                if (pick == 3) return $urandom_range(25, 80);
                if (pick == 4 && $urandom_range(0, 7) == 0) return $urandom_range(445, 520);
                return $urandom_range(2, 24);
            end
            REG_VOLUME_GAIN: begin
                if (pick == 0) return 32'd0;
                if (pick == 1) return 32'h0000_FFFF;
                return $urandom_range(0, 32'hFFFF);
            end
            REG_DECAY_START: begin
                if (pick == 0) return 32'd0;
                if (pick == 1) return 32'h03FF_FFFF;
                if (pick == 2) return 32'h0100_0000;
                return $urandom_range(0, 32'h03FF_FFFF);
            end
            REG_DECAY_STEP: begin
                if (pick == 0) return 32'd0;
                if (pick == 1) return 32'h03FF_FFFF;
                if (pick < 6) return $urandom_range(0, 32'h0004_0000);
                return $urandom_range(0, 32'h03FF_FFFF);
            end
            default: return '0;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic write_reg(etg_reg_t sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(sel));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_WAVE_SELECT: tone_cfg.wave_select = value[1:0];
            REG_PHASE_STEP:  tone_cfg.phase_step  = value;
            REG_TONE_LENGTH: tone_cfg.tone_length = value[19:0];
            REG_VOLUME_GAIN: tone_cfg.volume_gain = value[15:0];
            REG_DECAY_START: tone_cfg.decay_start = value[25:0];
            REG_DECAY_STEP:  tone_cfg.decay_step  = value[25:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic wait_all_samples();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples.size() != 0) @(posedge aclk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid   <= 1'b0;
                s_restart <= $urandom_range(0, 1);
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic send_tick(bit restart, bit fixed, tone_sample_t fixed_sample);
        tone_sample_t want;
        pace_sender();
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = synth_next_sample(restart);
        pending_samples.push_back(fixed ? fixed_sample : want);
        ticks_sent++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hold ready for a run, then drop it for a run
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            if (m_ready) begin
                m_ready <= 1'b0;
                rx_left <= $urandom_range(1, 24);
            end else begin
                m_ready <= 1'b1;
                rx_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 16);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    always @(posedge aclk) begin : check_samples
        tone_sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("transfer with nothing pending, pcm_sample %0d",
                                          m_pcm_sample));
            end else begin
                want = pending_samples.pop_front();
                if (m_pcm_sample !== want.pcm)
                    report_mismatch($sformatf("pcm_sample %0d, predicted %0d",
                                              m_pcm_sample, want.pcm));
                if (m_tone_active !== want.active)
                    report_mismatch($sformatf("tone_active %b, predicted %b",
                                              m_tone_active, want.active));
                if (m_last_sample !== want.last)
                    report_mismatch($sformatf("last_sample %b, predicted %b",
                                              m_last_sample, want.last));
            end
        end
    end

    initial begin
        int       phase_no;
        int       len;
        int       n;
        int       mid_write;
        int       stop_at;
        bit       noisy;
        bit       restart;
        etg_reg_t sel;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        build_quarter_sine();
        tone_cfg             = '0;
        tone_cfg.tone_length = 20'd1;
        phase_acc_q          = '0;
        sample_idx_q         = '0;
        decay_q              = '0;
        playing_q            = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                wait_all_samples();
                write_reg(directed_rows[k].reg_sel, directed_rows[k].value);
            end else begin
                send_tick(directed_rows[k].restart, directed_rows[k].fixed,
                          directed_rows[k].sample);
            end
        end

        phase_no = 0;
        stop_at  = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            wait_all_samples();
            for (int r = 0; r <= int'(REG_DECAY_STEP); r++) begin
                if (phase_no == 0 || $urandom_range(0, 2) == 0)
                    write_reg(etg_reg_t'(r), pick_reg_value(etg_reg_t'(r)));
            end
            if (phase_no == 1) write_reg(REG_TONE_LENGTH, 32'h000F_FFFF);
            if (phase_no == 2) write_reg(REG_TONE_LENGTH, $urandom_range(445, 470));
            len   = (tone_cfg.tone_length == 0) ? 1 : int'(tone_cfg.tone_length);
            noisy = ($urandom_range(0, 9) == 0);
            if (len > 600) begin
                n = $urandom_range(5, 30);
            end else if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, len);
            end else begin
                n = len + $urandom_range(0, 3);
            end
            mid_write = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : -1;
            for (int i = 0; i < n && ticks_sent < stop_at; i++) begin
                if (i == mid_write) begin
                    wait_all_samples();
                    sel = etg_reg_t'($urandom_range(0, 5));
                    write_reg(sel, pick_reg_value(sel));
                end
                if (noisy) begin
                    restart = $urandom_range(0, 1);
                end else if (i == 0) begin
                    restart = ($urandom_range(0, 7) != 0);
                end else begin
                    restart = ($urandom_range(0, 49) == 0);
                end
                send_tick(restart, 1'b0, '0);
            end
            phase_no++;
        end

        wait_all_samples();
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
